FILE: rtl/oabc_pkg.sv
`timescale 1ns / 1ps
package oabc_pkg;
  localparam int FOOTPRINT_SIDE_DEF = 4;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam logic [1:0] ACT_LUMA = 2'd0;
  localparam logic [1:0] ACT_FOOT = 2'd1;
  localparam logic [1:0] ACT_CHROMA = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [1:0] CFG_SHIFT = 2'd0;
  localparam logic [1:0] CFG_HORIZ = 2'd1;
  localparam logic [1:0] CFG_VERT = 2'd2;
  localparam logic [1:0] CFG_ROUND = 2'd3;
  localparam logic [63:0] WEIGHT_RESET = 64'd281479271743489;
  localparam int SUMW = 52;
  localparam int WSUMW = 36;

  // Item handed from the front to the back.
  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] d0;
    logic [15:0] d1;
    logic [7:0]  s0;
    logic [7:0]  s1;
    logic [7:0]  alpha;
    logic        covered;
    logic [31:0] coeff;
    logic        last;
  } work_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] luma_out;
    logic [15:0] u_out;
    logic [15:0] v_out;
    logic        chroma_written;
  } res_t;
endpackage

FILE: rtl/oabc_front.sv
`timescale 1ns / 1ps
module oabc_front #(
  parameter int FOOTPRINT_SIDE = 4,
  parameter int WEIGHT_BITS = 16
) (
  input  logic [1:0]  action,
  input  logic [15:0] dst_luma,
  input  logic [7:0]  src_luma,
  input  logic [7:0]  alpha,
  input  logic [15:0] dst_u,
  input  logic [15:0] dst_v,
  input  logic [7:0]  src_u,
  input  logic [7:0]  src_v,
  input  logic        covered,
  input  logic [1:0]  col_index,
  input  logic [1:0]  row_index,
  input  logic        last,
  input  logic [63:0] horiz_weights,
  input  logic [63:0] vert_weights,
  output oabc_pkg::work_t item
);
  import oabc_pkg::*;
  logic [15:0] hw, vw;
  logic [15:0] wmask;

  assign wmask = 16'((32'd1 << WEIGHT_BITS) - 32'd1);

  // Pick the weights; an index past the footprint weighs zero.
  always_comb begin
    hw = 16'(horiz_weights >> {col_index, 4'd0}) & wmask;
    vw = 16'(vert_weights >> {row_index, 4'd0}) & wmask;
    if (32'(col_index) >= FOOTPRINT_SIDE) hw = '0;
    if (32'(row_index) >= FOOTPRINT_SIDE) vw = '0;
    item.action = action;
    item.d0 = (action == ACT_LUMA) ? dst_luma : dst_u;
    item.d1 = dst_v;
    item.s0 = (action == ACT_LUMA) ? src_luma : src_u;
    item.s1 = src_v;
    item.alpha = alpha;
    item.covered = covered;
    item.coeff = hw * vw;
    item.last = last;
  end
endmodule

FILE: rtl/oabc_divider.sv
`timescale 1ns / 1ps
module oabc_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [59:0] num,
  input  logic [35:0] den,
  output logic        done,
  output logic [15:0] quot
);
  // Restoring divider, one quotient bit per cycle, saturated to 16 bits.
  logic [59:0] rem;
  logic [59:0] q;
  logic [5:0]  cnt;
  logic        busy;
  logic [96:0] trial;
  logic [60:0] shifted;

  assign shifted = {rem, q[59]};
  assign trial = {36'd0, shifted} - {61'd0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= '0;
        q <= num;
        cnt <= 6'd0;
      end else if (busy) begin
        if (!trial[96]) begin
          rem <= trial[59:0];
          q <= {q[58:0], 1'b1};
        end else begin
          rem <= shifted[59:0];
          q <= {q[58:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd59) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = (q[59:16] != '0) ? 16'hFFFF : q[15:0];
endmodule

FILE: rtl/oabc_back.sv
`timescale 1ns / 1ps
module oabc_back (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  oabc_pkg::work_t item,
  output logic        in_take,
  input  logic [3:0]  depth_shift,
  input  logic        round_enable,
  output logic        res_valid,
  output oabc_pkg::res_t res,
  input  logic        res_take
);
  import oabc_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  work_t cur;
  logic [3:0] sh;
  logic [16:0] m;
  logic [16:0] ap;
  logic [59:0] p0a, p0b, p1a, p1b;
  logic [59:0] n0, n1;
  logic [35:0] den;
  logic start;
  logic done0, done1;
  logic [15:0] q0, q1;
  logic [SUMW-1:0] su, sv;
  logic [WSUMW-1:0] sw;
  logic [15:0] ru, rv;
  logic avg;
  logic [SUMW-1:0] su_next, sv_next;
  logic [WSUMW-1:0] sw_next;

  assign sh = (depth_shift > 4'd8) ? 4'd8 : depth_shift;
  assign m = 17'((18'd256 << sh) - 18'd1);
  assign ap = 17'({9'd0, cur.alpha} << sh);
  assign in_take = (state == S_IDLE) && in_valid;
  assign den = avg ? sw : {19'd0, m};
  assign su_next = su + SUMW'(cur.coeff) * SUMW'(ru);
  assign sv_next = sv + SUMW'(cur.coeff) * SUMW'(rv);
  assign sw_next = sw + WSUMW'(cur.coeff);

  oabc_divider u_div0 (.clk, .rst, .start, .num(n0), .den, .done(done0), .quot(q0));
  oabc_divider u_div1 (.clk, .rst, .start, .num(n1), .den, .done(done1), .quot(q1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      start <= 1'b0;
      avg <= 1'b0;
      su <= '0;
      sv <= '0;
      sw <= '0;
    end else begin
      start <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) begin
          cur <= item;
          avg <= 1'b0;
          state <= (item.action == ACT_NONE) ? S_IDLE : S_MUL;
        end
        S_MUL: begin
          // Blend products, registered before the adder.
          p0a <= 60'(cur.d0) * 60'(m - ap);
          p0b <= 60'({9'd0, cur.s0} << sh) * 60'(ap);
          p1a <= 60'(cur.d1) * 60'(m - ap);
          p1b <= 60'({9'd0, cur.s1} << sh) * 60'(ap);
          state <= S_DIV;
          avg <= 1'b1;
        end
        S_DIV: begin
          if (avg) begin
            avg <= 1'b0;
            n0 <= p0a + p0b + (round_enable ? 60'(m >> 1) : 60'd0);
            n1 <= p1a + p1b + (round_enable ? 60'(m >> 1) : 60'd0);
            start <= 1'b1;
          end else if (done0 && done1) begin
            if (cur.action == ACT_FOOT) begin
              state <= S_ACC;
              rv <= cur.covered ? q1 : cur.d1;
              ru <= cur.covered ? q0 : cur.d0;
            end else begin
              res.kind <= cur.action;
              res.luma_out <= (cur.action == ACT_LUMA) ? q0 : 16'd0;
              res.u_out <= (cur.action == ACT_LUMA) ? 16'd0 : q0;
              res.v_out <= (cur.action == ACT_LUMA) ? 16'd0 : q1;
              res.chroma_written <= (cur.action != ACT_LUMA);
              res_valid <= 1'b1;
              state <= S_OUT;
            end
          end
        end
        S_ACC: begin
          if (!avg) begin
            if (!cur.last) begin
              su <= su_next;
              sv <= sv_next;
              sw <= sw_next;
              state <= S_IDLE;
            end else if (sw_next == '0) begin
              res.kind <= ACT_FOOT;
              res.luma_out <= '0;
              res.u_out <= cur.d0;
              res.v_out <= cur.d1;
              res.chroma_written <= 1'b0;
              res_valid <= 1'b1;
              su <= '0;
              sv <= '0;
              sw <= '0;
              state <= S_OUT;
            end else begin
              su <= su_next;
              sv <= sv_next;
              sw <= sw_next;
              n0 <= {8'd0, su_next} + 60'(sw_next >> 1);
              n1 <= {8'd0, sv_next} + 60'(sw_next >> 1);
              avg <= 1'b1;
              start <= 1'b1;
            end
          end else if (done0 && done1) begin
            res.kind <= ACT_FOOT;
            res.luma_out <= '0;
            res.u_out <= q0;
            res.v_out <= q1;
            res.chroma_written <= 1'b1;
            res_valid <= 1'b1;
            su <= '0;
            sv <= '0;
            sw <= '0;
            avg <= 1'b0;
            state <= S_OUT;
          end
        end
        S_OUT: if (res_take) begin
          res_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/overlay_alpha_blend_chroma_weighted.sv
`timescale 1ns / 1ps
// Channel    Handshake        Payload
// input      push / full      action .. last
// result     pop / empty      kind, luma_out, u_out, v_out, chroma_written
// config     cfg_we           cfg_index, cfg_data (64 bits)
// Each blend item passes a product state and a 60-step restoring divider;
// a last footprint sample with a nonzero weight sum runs the divider twice.
// Reset (rst, synchronous) clears the sums and restores register defaults.
// A two-entry queue holds requests while the back end works; full stalls push.
module overlay_alpha_blend_chroma_weighted #(
  parameter int FOOTPRINT_SIDE = oabc_pkg::FOOTPRINT_SIDE_DEF,
  parameter int WEIGHT_BITS = oabc_pkg::WEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [15:0] dst_luma,
  input  logic [7:0]  src_luma,
  input  logic [7:0]  alpha,
  input  logic [15:0] dst_u,
  input  logic [15:0] dst_v,
  input  logic [7:0]  src_u,
  input  logic [7:0]  src_v,
  input  logic        covered,
  input  logic [1:0]  col_index,
  input  logic [1:0]  row_index,
  input  logic        last,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [15:0] luma_out,
  output logic [15:0] u_out,
  output logic [15:0] v_out,
  output logic        chroma_written,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import oabc_pkg::*;

  logic [3:0]  depth_shift;
  logic [63:0] horiz_weights, vert_weights;
  logic        round_enable;
  work_t       fitem;
  work_t       q [2];
  logic [1:0]  cnt;
  logic        rd, wr, take, res_valid;
  res_t        res;

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_shift <= '0;
      horiz_weights <= WEIGHT_RESET;
      vert_weights <= WEIGHT_RESET;
      round_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHIFT: depth_shift <= cfg_data[3:0];
        CFG_HORIZ: horiz_weights <= cfg_data;
        CFG_VERT:  vert_weights <= cfg_data;
        CFG_ROUND: round_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  oabc_front #(.FOOTPRINT_SIDE(FOOTPRINT_SIDE), .WEIGHT_BITS(WEIGHT_BITS)) u_front (
    .action, .dst_luma, .src_luma, .alpha, .dst_u, .dst_v, .src_u, .src_v,
    .covered, .col_index, .row_index, .last, .horiz_weights, .vert_weights,
    .item(fitem)
  );

  // Two-entry request queue: slot 0 is the head.
  assign full = (cnt == 2'd2);
  assign wr = push && !full;
  assign rd = take;
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
      if (rd) begin
        // Advance the head; a request arriving behind a lone head becomes the head.
        q[0] <= (wr && cnt == 2'd1) ? fitem : q[1];
      end else if (wr) begin
        q[cnt[0]] <= fitem;
      end
    end
  end

  oabc_back u_back (
    .clk, .rst, .in_valid(cnt != 2'd0), .item(q[0]), .in_take(take),
    .depth_shift, .round_enable, .res_valid, .res, .res_take(pop)
  );

  // Drive the result side straight from the back end's output register.
  assign empty = !res_valid;
  assign kind = res.kind;
  assign luma_out = res.luma_out;
  assign u_out = res.u_out;
  assign v_out = res.v_out;
  assign chroma_written = res.chroma_written;
endmodule
